// File: design/ocp_pkg.sv
// Shared types, constants and helper functions for the orbit camera position block.
// No dependencies; every other file in design/ imports this package.
`default_nettype none
package ocp_pkg;

   localparam int CORDIC_W   = 34;             // Q2.30 plus headroom
   localparam int TURN_W     = 32;             // angle scaled to a 32-bit turn
   localparam int MUL_A_W    = CORDIC_W;       // multiplicand: sine or cosine
   localparam int MUL_B_W    = 27;             // multiplier: radius or r*cos(p)
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int MAX_STEPS  = 24;
   localparam int POS_W      = 17;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [15:0] MIN_RADIUS_RST = 16'd26;
   localparam logic [15:0] MAX_RADIUS_RST = 16'd12800;
   localparam logic [15:0] RADIUS_RST     = 16'd2560;

   typedef enum logic { CSR_MIN_RADIUS = 1'b0, CSR_MAX_RADIUS = 1'b1 } csr_index_type;
   typedef enum logic { FUNC_ADJUST = 1'b0, FUNC_SET = 1'b1 } func_type;

   // arctangent of 2^-i in units of a 32-bit turn
   function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
      logic [TURN_W-1:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

   // saturate a rounded product to the 17-bit position range
   function automatic logic [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v > $signed(PROD_W'(65535))) r = 17'h0FFFF;
      else if (v < -$signed(PROD_W'(65536))) r = 17'h10000;
      else r = v[POS_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/ocp_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per clock.
// Depends on ocp_pkg (gain, arctangent table, widths).
`default_nettype none
module ocp_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [ocp_pkg::TURN_W-1:0]           angle,
   output logic                                      done,
   output logic signed [ocp_pkg::CORDIC_W-1:0]       cos_out,
   output logic signed [ocp_pkg::CORDIC_W-1:0]       sin_out
);
   import ocp_pkg::*;

   localparam int NSTEP = (STEPS < MAX_STEPS) ? STEPS : MAX_STEPS;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [CORDIC_W-1:0] dx, dy, at;
   logic [4:0]                 cnt_ff;
   logic                       busy_ff, done_ff, flip_ff;
   logic [TURN_W-1:0]          a_fold;
   logic                       fold;

   // left half plane: rotate by half a turn, negate at the end
   assign fold   = angle[TURN_W-1] ^ angle[TURN_W-2];
   assign a_fold = fold ? (angle ^ {1'b1, {(TURN_W-1){1'b0}}}) : angle;

   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;
   assign at = $signed({{(CORDIC_W-TURN_W){1'b0}}, atan_turn(cnt_ff)});

   always_comb begin
      if (!z_ff[CORDIC_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         flip_ff <= fold;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= $signed({{(CORDIC_W-TURN_W){a_fold[TURN_W-1]}}, a_fold});
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(NSTEP - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

// File: design/ocp_sermul.sv
// Bit-serial signed multiplier: one multiplier bit per clock, LSB first.
// Depends on ocp_pkg (operand and product widths).
`default_nettype none
module ocp_sermul (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [ocp_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic signed [ocp_pkg::MUL_B_W-1:0]  mul_b,
   output logic                                     done,
   output logic signed [ocp_pkg::PROD_W-1:0]        prod
);
   import ocp_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic signed [PROD_W-1:0] a_ff, acc_ff, term;
   logic [MUL_B_W-1:0]       b_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff, done_ff;

   assign term = b_ff[0] ? a_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         a_ff    <= PROD_W'(mul_a);
         b_ff    <= mul_b;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         // sign bit of the multiplier carries negative weight
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            acc_ff  <= acc_ff - term;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            acc_ff <= acc_ff + term;
         end
         a_ff   <= a_ff <<< 1;
         b_ff   <= b_ff >> 1;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// File: design/orbit_camera_position.sv
// Orbit camera position: state update, CORDIC sequencing and serial products.
// Depends on ocp_pkg, ocp_cordic and ocp_sermul.
//
// Each request beat adjusts or sets azimuth, polar angle and radius, then the block
// returns the camera position and the new state as one response beat. The single
// CORDIC runs once for the azimuth and once for the polar angle, and the bit-serial
// multiplier then forms r*cos(p), r*sin(p), and the two products with the azimuth
// terms. A new request is taken once the previous item has moved into the response
// register; the response waits there until taken.
`default_nettype none
module orbit_camera_position #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic signed [15:0] req_azimuth_value,
   input  wire logic signed [15:0] req_polar_value,
   input  wire logic signed [15:0] req_radius_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [16:0]      rsp_pos_x,
   output logic signed [16:0]      rsp_pos_y,
   output logic signed [16:0]      rsp_pos_z,
   output logic [15:0]             rsp_radius_now,
   output logic [15:0]             rsp_azimuth_now,
   output logic signed [15:0]      rsp_polar_now,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ocp_pkg::*;

   localparam longint CAP_L = (longint'(1) << (ANGLE_BITS - 2)) -
      (((longint'(1) << ANGLE_BITS) * 1591549 + 500000000) / 1000000000);
   localparam logic signed [31:0] CAP = 32'(CAP_L);
   localparam logic [15:0] AZ_MASK = (ANGLE_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << ANGLE_BITS) - 32'd1);
   localparam logic signed [PROD_W-1:0] RND22 = PROD_W'(64'd1 << 21);
   localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(64'd1 << 29);
   localparam logic signed [PROD_W-1:0] RND38 = PROD_W'(64'd1 << 37);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CA, ST_CP, ST_M1, ST_M2, ST_M3, ST_M4, ST_OUT
   } state_type;

   state_type state_ff;
   logic [15:0] min_radius_ff, max_radius_ff;
   logic [15:0] azimuth_ff, radius_ff;
   logic signed [15:0] elevation_ff;
   logic [15:0] az_in, rad_in;
   logic signed [15:0] el_in;
   logic cor_start_ff, mul_start_ff;
   logic signed [CORDIC_W-1:0] ca_ff, sa_ff, cp_ff, sp_ff;
   logic signed [MUL_B_W-1:0]  rc_ff;
   logic [POS_W-1:0] x_ff, y_ff, z_ff;
   logic rsp_valid_ff;
   logic [POS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [15:0] rsp_r_ff, rsp_a_ff, rsp_p_ff;

   // ---- state update at the request beat
   logic signed [31:0] e_sum, e_cl;
   logic signed [17:0] r_sum, r_set, max18, min18;

   assign max18 = $signed({2'b00, max_radius_ff});
   assign min18 = $signed({2'b00, min_radius_ff});

   always_comb begin
      e_sum = $signed({{16{elevation_ff[15]}}, elevation_ff}) +
              $signed({{16{req_polar_value[15]}}, req_polar_value});
      e_cl = e_sum;
      if (e_cl > CAP) e_cl = CAP;
      if (e_cl < -CAP) e_cl = -CAP;
      if (e_cl > 32'sd32767) e_cl = 32'sd32767;
      if (e_cl < -32'sd32768) e_cl = -32'sd32768;

      r_sum = $signed({2'b00, radius_ff}) +
              $signed({{2{req_radius_value[15]}}, req_radius_value});
      if (r_sum <= 18'sd1) r_sum = 18'sd1;
      if (r_sum >= max18) r_sum = max18;

      r_set = $signed({{2{req_radius_value[15]}}, req_radius_value});
      if (r_set < min18) r_set = min18;
      if (r_set > max18) r_set = max18;

      if (req_func == FUNC_SET) begin
         az_in  = req_azimuth_value & AZ_MASK;
         el_in  = req_polar_value;
         rad_in = r_set[15:0];
      end else begin
         az_in  = (azimuth_ff + req_azimuth_value) & AZ_MASK;
         el_in  = e_cl[15:0];
         rad_in = r_sum[15:0];
      end
   end

   // ---- CORDIC angle: binary angle placed at the top of a 32-bit turn
   logic [31:0] az_ext, el_ext, cor_angle;
   logic        cor_done;
   logic signed [CORDIC_W-1:0] cor_cos, cor_sin;

   assign az_ext = {16'd0, azimuth_ff};
   assign el_ext = {{16{elevation_ff[15]}}, elevation_ff};
   assign cor_angle = (state_ff == ST_CP) ?
      {el_ext[ANGLE_BITS-1:0], {(TURN_W-ANGLE_BITS){1'b0}}} :
      {az_ext[ANGLE_BITS-1:0], {(TURN_W-ANGLE_BITS){1'b0}}};

   ocp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start_ff),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   // ---- serial multiplier operands
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_done;
   logic signed [PROD_W-1:0]  mul_prod, p22, p30, p38;

   always_comb begin
      case (state_ff)
         ST_M1:   begin mul_a = cp_ff; mul_b = MUL_B_W'({1'b0, radius_ff}); end
         ST_M2:   begin mul_a = sp_ff; mul_b = MUL_B_W'({1'b0, radius_ff}); end
         ST_M3:   begin mul_a = ca_ff; mul_b = rc_ff; end
         default: begin mul_a = sa_ff; mul_b = rc_ff; end
      endcase
   end

   ocp_sermul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign p22 = (mul_prod + RND22) >>> 22;
   assign p30 = (mul_prod + RND30) >>> 30;
   assign p38 = (mul_prod + RND38) >>> 38;

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_radius_ff <= MIN_RADIUS_RST;
         max_radius_ff <= MAX_RADIUS_RST;
         azimuth_ff    <= '0;
         elevation_ff  <= '0;
         radius_ff     <= RADIUS_RST;
         cor_start_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cor_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         if (csr_wr_en) begin
            if (csr_index == CSR_MIN_RADIUS) min_radius_ff <= csr_wdata;
            else max_radius_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  azimuth_ff   <= az_in;
                  elevation_ff <= el_in;
                  radius_ff    <= rad_in;
                  cor_start_ff <= 1'b1;
                  state_ff     <= ST_CA;
               end
            end
            ST_CA: begin
               if (cor_done) begin
                  ca_ff <= cor_cos;
                  sa_ff <= cor_sin;
                  cor_start_ff <= 1'b1;
                  state_ff <= ST_CP;
               end
            end
            ST_CP: begin
               if (cor_done) begin
                  cp_ff <= cor_cos;
                  sp_ff <= cor_sin;
                  mul_start_ff <= 1'b1;
                  state_ff <= ST_M1;
               end
            end
            ST_M1: begin
               if (mul_done) begin
                  rc_ff <= p22[MUL_B_W-1:0];
                  mul_start_ff <= 1'b1;
                  state_ff <= ST_M2;
               end
            end
            ST_M2: begin
               if (mul_done) begin
                  y_ff <= sat_pos(p30);
                  mul_start_ff <= 1'b1;
                  state_ff <= ST_M3;
               end
            end
            ST_M3: begin
               if (mul_done) begin
                  x_ff <= sat_pos(p38);
                  mul_start_ff <= 1'b1;
                  state_ff <= ST_M4;
               end
            end
            ST_M4: begin
               if (mul_done) begin
                  z_ff <= sat_pos(p38);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hand over to the response register once it is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff <= x_ff;
                  rsp_y_ff <= y_ff;
                  rsp_z_ff <= z_ff;
                  rsp_r_ff <= radius_ff;
                  rsp_a_ff <= azimuth_ff;
                  rsp_p_ff <= elevation_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_pos_z       = rsp_z_ff;
   assign rsp_radius_now  = rsp_r_ff;
   assign rsp_azimuth_now = rsp_a_ff;
   assign rsp_polar_now   = rsp_p_ff;

endmodule
`default_nettype wire

// File: test/orbit_camera_position_tb.sv
// Self-checking testbench for orbit_camera_position: directed table, then random beats.
// Depends on ocp_pkg (register and function codes) and the design under design/.
`default_nettype none
module orbit_camera_position_tb;
   import ocp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POLAR_CAP = 16280;
   localparam int WATCHDOG  = 6000;
   localparam longint GAIN_Q30 = 652032874;

   typedef struct {
      logic signed [16:0] x, y, z;
      logic [15:0]        r, a;
      logic signed [15:0] p;
   } cam_out_t;

   typedef struct {
      func_type    f;
      int          av, pv, rv;
      bit          typed;
      int          er, ea, ep;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic signed [15:0] req_azimuth_value = '0, req_polar_value = '0, req_radius_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [15:0] rsp_radius_now, rsp_azimuth_now;
   logic signed [15:0] rsp_polar_now;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   orbit_camera_position dut (.*);

   always #5 clock = ~clock;

   // camera model state
   longint cam_min_r, cam_max_r, cam_az, cam_el, cam_r;
   cam_out_t pending_pos[$];
   int errors = 0, sent = 0, checked = 0, idle_cycles = 0;

   longint atan_tab[16] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D };

   function automatic void sin_cos(input longint ang, output longint c, output longint s);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = (ang & 'hFFFF) << 16;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (a >= 'h40000000 && a < 'hC0000000) begin
         a = (a - 'h80000000) & 'hFFFFFFFF;
         flip = 1;
      end
      z = (a >= 'h80000000) ? a - 64'sd4294967296 : a;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint round_sh(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [16:0] clip_pos(input longint v);
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[16:0];
   endfunction

   function automatic cam_out_t camera_update(input func_type f, input longint av,
                                              input longint pv, input longint rv);
      cam_out_t o;
      longint e, r, ca, sa, cp, sp, rc;
      if (f == FUNC_ADJUST) begin
         e = cam_el + pv;
         r = cam_r + rv;
         cam_az = (cam_az + av) & 'hFFFF;
         if (e > POLAR_CAP) e = POLAR_CAP;
         if (e < -POLAR_CAP) e = -POLAR_CAP;
         cam_el = e;
         if (r <= 1) r = 1;
         if (r >= cam_max_r) r = cam_max_r;
         cam_r = r;
      end else begin
         cam_az = av & 'hFFFF;
         cam_el = pv;
         if (rv < cam_min_r) rv = cam_min_r;
         if (rv > cam_max_r) rv = cam_max_r;
         cam_r = rv;
      end
      sin_cos(cam_az, ca, sa);
      sin_cos(cam_el, cp, sp);
      rc  = round_sh(cam_r * cp, 22);
      o.x = clip_pos(round_sh(rc * ca, 38));
      o.y = clip_pos(round_sh(cam_r * sp, 30));
      o.z = clip_pos(round_sh(rc * sa, 38));
      o.r = cam_r[15:0];
      o.a = cam_az[15:0];
      o.p = cam_el[15:0];
      return o;
   endfunction

   // one request beat; the expected result is queued at the accepting edge
   task automatic send_beat(input func_type f, input int av, input int pv, input int rv,
                            input bit typed, input int er, input int ea, input int ep);
      cam_out_t o;
      int gap;
      req_valid <= 1'b1;
      req_func <= f;
      req_azimuth_value <= av[15:0];
      req_polar_value <= pv[15:0];
      req_radius_value <= rv[15:0];
      do @(posedge clock); while (!req_ready);
      o = camera_update(f, longint'($signed(av[15:0])), longint'($signed(pv[15:0])),
                        longint'($signed(rv[15:0])));
      if (typed) begin
         o.r = er[15:0]; o.a = ea[15:0]; o.p = ep[15:0];
      end
      pending_pos.push_back(o);
      sent++;
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      if (sent % 200 > 150) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_idle();
      if (req_valid) req_valid <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      if (idx == CSR_MIN_RADIUS) cam_min_r = val & 'hFFFF;
      else cam_max_r = val & 'hFFFF;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_beats(input int n);
      int k, av, pv, rv;
      func_type f;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         f = (k >= 6 && k != 8) ? FUNC_SET : FUNC_ADJUST;
         if (k < 6) begin
            av = $urandom_range(0, 4000) - 2000;
            pv = $urandom_range(0, 6000) - 3000;
            rv = $urandom_range(0, 1200) - 600;
         end else if (k < 8) begin
            av = $urandom_range(0, 65535);
            pv = $urandom_range(0, 32560) - 16280;
            rv = $urandom_range(0, 13000);
         end else begin
            av = $urandom_range(0, 65535);
            pv = $urandom_range(0, 65535);
            rv = $urandom_range(0, 65535);
         end
         send_beat(f, av, pv, rv, 0, 0, 0, 0);
      end
   endtask

   // rows after reset: min 26, max 12800, state az 0 / el 0 / r 2560
   row_t dir_rows[] = '{
      '{FUNC_ADJUST, 0, 0, 0, 1, 2560, 0, 0},
      '{FUNC_SET, 32767, 32767, 32767, 1, 12800, 32767, 32767},
      '{FUNC_SET, -32768, -32768, -32768, 1, 26, 32768, -32768},
      '{FUNC_ADJUST, 0, 32767, 0, 1, 26, 32768, -1},
      '{FUNC_ADJUST, 0, 32767, 0, 1, 26, 32768, 16280},
      '{FUNC_ADJUST, 0, -32768, 0, 1, 26, 32768, -16280},
      '{FUNC_ADJUST, 1, 0, -32768, 1, 1, 32769, -16280},
      '{FUNC_ADJUST, -1, 0, 32767, 1, 12800, 32768, -16280},
      '{FUNC_SET, 16384, 0, 2560, 1, 2560, 16384, 0},
      '{FUNC_SET, 0, 16384, 256, 1, 256, 0, 16384},
      '{FUNC_SET, -16384, -16384, 1, 1, 26, 49152, -16384},
      '{FUNC_ADJUST, 32767, 0, 0, 1, 26, 16383, -16280},
      '{FUNC_SET, 8192, 4096, 12800, 1, 12800, 8192, 4096},
      '{FUNC_SET, 12345, -2000, 5000, 0, 0, 0, 0},
      '{FUNC_ADJUST, -7000, 900, -77, 0, 0, 0, 0},
      '{FUNC_SET, 40000, 16280, 65535, 0, 0, 0, 0},
      '{FUNC_SET, 24576, -16280, 700, 0, 0, 0, 0},
      '{FUNC_ADJUST, 0, 0, 1, 0, 0, 0, 0}
   };

   initial begin
      cam_min_r = 26; cam_max_r = 12800; cam_az = 0; cam_el = 0; cam_r = 2560;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_beat(dir_rows[i].f, dir_rows[i].av, dir_rows[i].pv, dir_rows[i].rv,
                   dir_rows[i].typed, dir_rows[i].er, dir_rows[i].ea, dir_rows[i].ep);
      random_beats(200);
      drain_and_idle();
      write_csr(CSR_MIN_RADIUS, 0);
      write_csr(CSR_MAX_RADIUS, 65535);
      random_beats(180);
      drain_and_idle();
      // crossed bounds: max wins, including zero radius
      write_csr(CSR_MIN_RADIUS, 65535);
      write_csr(CSR_MAX_RADIUS, 0);
      random_beats(100);
      drain_and_idle();
      write_csr(CSR_MIN_RADIUS, 1000);
      write_csr(CSR_MAX_RADIUS, 500);
      random_beats(100);
      drain_and_idle();
      write_csr(CSR_MIN_RADIUS, $urandom_range(0, 3000));
      write_csr(CSR_MAX_RADIUS, $urandom_range(3000, 65535));
      random_beats(300);
      drain_and_idle();
      $display("%0d request beats sent, %0d response beats checked over 5 radius settings",
               sent, checked);
      $display("directed extremes, clamps, wraps and crossed bounds included");
      if (errors == 0) $display("orbit_camera_position_tb: clean");
      else $display("orbit_camera_position_tb: errors");
      $finish;
   end

   // response side: random stalls, some long, with stall-free stretches
   int stall = 0;
   always @(posedge clock) begin
      if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ((sent % 250) < 200 && $urandom_range(0, 3) == 0)
            stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      end
   end

   always @(posedge clock) begin
      cam_out_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pos.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            e = pending_pos.pop_front();
            checked++;
            if (rsp_pos_x !== e.x) begin
               $error("pos_x expected %0d got %0d", e.x, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.y) begin
               $error("pos_y expected %0d got %0d", e.y, rsp_pos_y); errors++;
            end
            if (rsp_pos_z !== e.z) begin
               $error("pos_z expected %0d got %0d", e.z, rsp_pos_z); errors++;
            end
            if (rsp_radius_now !== e.r) begin
               $error("radius_now expected %0d got %0d", e.r, rsp_radius_now); errors++;
            end
            if (rsp_azimuth_now !== e.a) begin
               $error("azimuth_now expected %0d got %0d", e.a, rsp_azimuth_now); errors++;
            end
            if (rsp_polar_now !== e.p) begin
               $error("polar_now expected %0d got %0d", e.p, rsp_polar_now); errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d responses outstanding", pending_pos.size());
         $display("orbit_camera_position_tb: errors");
         $finish;
      end
   end
endmodule
`default_nettype wire
